// ===== rtl/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types, opcodes and saturation helper of the quaternion ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package qalu_pkg;

  localparam int unsigned DW = 32;   // component width
  localparam int unsigned QW = 65;   // sum of four squares, carry included
  localparam int unsigned SW = 66;   // signed sum of four full products

  typedef logic signed [DW-1:0] fx_t;
  typedef fx_t [3:0] quat_t;         // index 0 is w, 1 x, 2 y, 3 z

  localparam fx_t FX_MAX = 32'sh7fff_ffff;
  localparam fx_t FX_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_ADDVEC  = 4'd1,
    OP_DOT     = 4'd2,
    OP_SCALE   = 4'd3,
    OP_CONJ    = 4'd4,
    OP_NEG     = 4'd5,
    OP_NORMSQ  = 4'd6,
    OP_NORM    = 4'd7,
    OP_UNIT    = 4'd8,
    OP_INV     = 4'd9,
    OP_PRODUCT = 4'd10,
    OP_EQUAL   = 4'd11,
    OP_NONE    = 4'd15   // any opcode without an operation
  } op_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_ROOT,
    SQ_DIV,
    SQ_FIN
  } seq_state_e;

  typedef struct packed {
    op_e   op;
    quat_t a;
    quat_t b;
  } item_t;

  typedef struct packed {
    quat_t r;
    fx_t   s;
    logic  eq;
    logic  ov;
    logic  dz;
  } result_t;

  typedef struct packed {
    logic go;
    op_e  op;
  } seq_cmd_t;

  typedef struct packed {
    logic idle;
    logic fin;
  } seq_sts_t;

  typedef struct packed {
    fx_t  v;
    logic ov;
  } sat_t;

  // Clamp a wide signed value to 32 bits.
  function automatic sat_t sat32(input logic signed [SW-1:0] v);
    sat_t res;
    if ((&v[SW-1:DW-1]) || !(|v[SW-1:DW-1])) begin
      res.v  = v[DW-1:0];
      res.ov = 1'b0;
    end else begin
      res.v  = v[SW-1] ? FX_MIN : FX_MAX;
      res.ov = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quaternion_alu.sv =====
// ----------------------------------------------------------------------------
// quaternion_alu
// Quaternion arithmetic unit in signed fixed point with saturation.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   command   in         start / busy          opcode_i, a_*_i, b_*_i
//   result    out        done_o (one cycle)    r_*_o, scalar_out_o, flags
//
// An item is taken at a rising edge where start is high and busy is low.
// Add, vector add, dot, scale, conjugate, negate, squared norm, Hamilton
// product and equality run one item per cycle while the root and divider
// unit is idle; each result passes the queue and product stage into the output register.
// Norm, inverse and normalise use the shared root and divider unit, where NW =
// 32 + 2 * FRAC_BITS is the quotient width; it works one bit per cycle and
// holds the items behind it until it finishes.
// Reset empties the two-entry command queue and the pipeline. The result
// side cannot stall; busy rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  opcode_i,
  input  logic [31:0] a_w_i,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] a_z_i,
  input  logic [31:0] b_w_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [31:0] b_z_i,
  output logic        done_o,
  output logic [31:0] r_w_o,
  output logic [31:0] r_x_o,
  output logic [31:0] r_y_o,
  output logic [31:0] r_z_o,
  output logic [31:0] scalar_out_o,
  output logic        equal_flag_o,
  output logic        overflow_flag_o,
  output logic        divzero_flag_o
);
  import qalu_pkg::*;

  quat_t   a_in, b_in;
  item_t   head;
  logic    head_vld, pop;
  result_t res;

  // Component 0 is the scalar part.
  assign a_in = {a_z_i, a_y_i, a_x_i, a_w_i};
  assign b_in = {b_z_i, b_y_i, b_x_i, b_w_i};

  qalu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .opcode_i  (opcode_i),
    .a_i       (a_in),
    .b_i       (b_in),
    .busy_o    (busy),
    .head_vld_o(head_vld),
    .head_o    (head),
    .pop_i     (pop)
  );

  qalu_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_vld_i(head_vld),
    .head_i    (head),
    .pop_o     (pop),
    .out_vld_o (done_o),
    .res_o     (res)
  );

  assign r_w_o           = res.r[0];
  assign r_x_o           = res.r[1];
  assign r_y_o           = res.r[2];
  assign r_z_o           = res.r[3];
  assign scalar_out_o    = res.s;
  assign equal_flag_o    = res.eq;
  assign overflow_flag_o = res.ov;
  assign divzero_flag_o  = res.dz;

  // A zero quaternion given to normalise or inverse yields an all-zero result.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && divzero_flag_o |-> r_w_o == '0 && r_x_o == '0 && r_y_o == '0
      && r_z_o == '0 && scalar_out_o == '0 && !overflow_flag_o)
    else $error("divide-by-zero result carries data");

  // A comparison never saturates and never sets the divide flag.
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && equal_flag_o |-> !overflow_flag_o && !divzero_flag_o
      && scalar_out_o == '0)
    else $error("equality result mixed with other flags");

  // The queue can only fill through an accepted item.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

endmodule

`default_nettype wire

// ===== rtl/qalu_front.sv =====
// ----------------------------------------------------------------------------
// qalu_front
// Takes items, maps the opcode onto an operation and holds them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [3:0]      opcode_i,
  input  qalu_pkg::quat_t a_i,
  input  qalu_pkg::quat_t b_i,
  output logic            busy_o,
  output logic            head_vld_o,
  output qalu_pkg::item_t head_o,
  input  logic            pop_i
);
  import qalu_pkg::*;

  localparam int unsigned QD = 2;

  item_t       in_item;
  item_t       mem_q [QD];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  always_comb begin
    in_item.a  = a_i;
    in_item.b  = b_i;
    in_item.op = (opcode_i <= OP_EQUAL) ? op_e'(opcode_i) : OP_NONE;
  end

  assign busy_o     = (cnt_q == 2'(QD));
  assign head_vld_o = (cnt_q != 2'd0);
  assign head_o     = mem_q[rp_q];
  assign push       = start_i && !busy_o;
  assign pop        = pop_i && head_vld_o;
  assign cnt_d      = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qalu_seq.sv =====
// ----------------------------------------------------------------------------
// qalu_seq
// Multi-cycle unit for norm, normalise and inverse: a digit-by-digit square
// root followed by four restoring dividers that share one denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_seq #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qalu_pkg::seq_cmd_t    cmd_i,
  input  logic [qalu_pkg::QW-1:0] sum_i,
  input  qalu_pkg::quat_t       a_i,
  output qalu_pkg::seq_sts_t    sts_o,
  output qalu_pkg::result_t     res_o
);
  import qalu_pkg::*;

  localparam int unsigned NW = DW + 2 * FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [63:0]   ROOT_BIT0 = 64'h4000_0000_0000_0000;
  localparam logic [QW-1:0] CARRY_ROOT = 65'h1_0000_0000;

  seq_state_e      state_q, state_d;
  op_e             op_q;
  quat_t           ah_q;
  result_t         res_q;
  logic            div_q;
  logic [63:0]     v_q, root_q, bit_q;
  logic [QW-1:0]   den_q;
  logic [NW-1:0]   num_q [4];
  logic [QW-1:0]   rem_q [4];
  logic [NW-1:0]   quo_q [4];
  logic [3:0]      neg_q;
  logic [CW-1:0]   cnt_q;

  logic [63:0]     trial, root_n, v_n;
  logic            root_ge;
  quat_t           src_a;
  logic            src_inv;
  logic [DW-1:0]   mag [4];
  logic [NW-1:0]   num_init [4];
  logic [3:0]      neg_init;
  logic [QW-1:0]   den_init;
  logic [QW:0]     rem2 [4];
  logic [QW-1:0]   rem_n [4];
  logic [3:0]      dge;
  result_t         div_res;
  logic            sum_zero;

  assign sum_zero = (sum_i == '0);

  // One result bit of the square root per cycle.
  always_comb begin
    trial   = root_q + bit_q;
    root_ge = (v_q >= trial);
    root_n  = root_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
    v_n     = root_ge ? (v_q - trial) : v_q;
  end

  // Divider set-up, either straight from a command or after the root.
  always_comb begin
    src_a   = (state_q == SQ_IDLE) ? a_i : ah_q;
    src_inv = (state_q == SQ_IDLE) ? (cmd_i.op == OP_INV) : (op_q == OP_INV);
    for (int i = 0; i < 4; i++) begin
      mag[i]      = src_a[i][DW-1] ? (~src_a[i] + 1'b1) : src_a[i];
      num_init[i] = src_inv ? (NW'(mag[i]) << (2 * FRAC_BITS))
                            : (NW'(mag[i]) << FRAC_BITS);
      neg_init[i] = (|src_a[i]) && (src_a[i][DW-1] ^ (src_inv && (i != 0)));
    end
    if (state_q == SQ_IDLE) begin
      den_init = (cmd_i.op == OP_INV) ? sum_i : CARRY_ROOT;
    end else begin
      den_init = QW'(root_n);
    end
  end

  // One quotient bit per lane and cycle.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem2[i]  = {rem_q[i], num_q[i][NW-1]};
      dge[i]   = (rem2[i] >= {1'b0, den_q});
      rem_n[i] = dge[i] ? QW'(rem2[i] - {1'b0, den_q}) : rem2[i][QW-1:0];
    end
  end

  // Saturate and sign the quotients. The limits are magnitudes, so they are
  // widened without sign extension.
  always_comb begin
    logic [NW-1:0] lim;
    logic [DW-1:0] qm;
    div_res = '0;
    for (int i = 0; i < 4; i++) begin
      lim = neg_q[i] ? NW'(unsigned'(FX_MIN)) : NW'(unsigned'(FX_MAX));
      if (quo_q[i] > lim) begin
        qm         = lim[DW-1:0];
        div_res.ov = 1'b1;
      end else begin
        qm = quo_q[i][DW-1:0];
      end
      div_res.r[i] = neg_q[i] ? (~qm + 1'b1) : qm;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (cmd_i.go) begin
          if (sum_zero && (cmd_i.op != OP_NORM)) begin
            state_d = SQ_FIN;
          end else if (sum_i[QW-1]) begin
            state_d = (cmd_i.op == OP_NORM) ? SQ_FIN : SQ_DIV;
          end else if (cmd_i.op == OP_INV) begin
            state_d = SQ_DIV;
          end else begin
            state_d = SQ_ROOT;
          end
        end
      end
      SQ_ROOT: begin
        if (bit_q[0]) begin
          state_d = (op_q == OP_NORM) ? SQ_FIN : SQ_DIV;
        end
      end
      SQ_DIV: begin
        if (cnt_q == CW'(1)) begin
          state_d = SQ_FIN;
        end
      end
      SQ_FIN: state_d = SQ_IDLE;
      default: state_d = SQ_IDLE;
    endcase
  end

  always_comb begin
    sts_o.idle = (state_q == SQ_IDLE);
    sts_o.fin  = (state_q == SQ_FIN);
    res_o      = div_q ? div_res : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SQ_IDLE: begin
        if (cmd_i.go) begin
          ah_q   <= a_i;
          op_q   <= cmd_i.op;
          res_q  <= '0;
          div_q  <= 1'b0;
          v_q    <= sum_i[63:0];
          root_q <= '0;
          bit_q  <= ROOT_BIT0;
          if (sum_zero && (cmd_i.op != OP_NORM)) begin
            res_q.dz <= 1'b1;
          end else if (sum_i[QW-1] && (cmd_i.op == OP_NORM)) begin
            res_q.s  <= FX_MAX;
            res_q.ov <= 1'b1;
          end else if (sum_i[QW-1] || (cmd_i.op == OP_INV)) begin
            div_q <= 1'b1;
            den_q <= den_init;
            cnt_q <= CW'(NW);
            neg_q <= neg_init;
            for (int i = 0; i < 4; i++) begin
              num_q[i] <= num_init[i];
              rem_q[i] <= '0;
              quo_q[i] <= '0;
            end
          end
        end
      end
      SQ_ROOT: begin
        v_q    <= v_n;
        root_q <= root_n;
        bit_q  <= bit_q >> 2;
        if (bit_q[0]) begin
          if (op_q == OP_NORM) begin
            if (|root_n[63:DW-1]) begin
              res_q.s  <= FX_MAX;
              res_q.ov <= 1'b1;
            end else begin
              res_q.s <= root_n[DW-1:0];
            end
          end else begin
            div_q <= 1'b1;
            den_q <= den_init;
            cnt_q <= CW'(NW);
            neg_q <= neg_init;
            for (int i = 0; i < 4; i++) begin
              num_q[i] <= num_init[i];
              rem_q[i] <= '0;
              quo_q[i] <= '0;
            end
          end
        end
      end
      SQ_DIV: begin
        cnt_q <= cnt_q - 1'b1;
        for (int i = 0; i < 4; i++) begin
          num_q[i] <= num_q[i] << 1;
          rem_q[i] <= rem_n[i];
          quo_q[i] <= {quo_q[i][NW-2:0], dge[i]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/qalu_back.sv =====
// ----------------------------------------------------------------------------
// qalu_back
// Execution side: a product stage, a reduce-and-saturate stage feeding the
// output register, and the multi-cycle unit for root and division.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_vld_i,
  input  qalu_pkg::item_t   head_i,
  output logic              pop_o,
  output logic              out_vld_o,
  output qalu_pkg::result_t res_o
);
  import qalu_pkg::*;

  typedef logic signed [2*DW-1:0] prod_t;
  typedef logic signed [SW-1:0]   wide_t;

  // Product slots: squares or a_i*b_i, a_i*b_w, then the cross terms.
  localparam int unsigned P_D0 = 0,  P_D1 = 1,  P_D2 = 2,  P_D3 = 3;
  localparam int unsigned P_S1 = 4,  P_S2 = 5,  P_S3 = 6;
  localparam int unsigned P_01 = 7,  P_02 = 8,  P_03 = 9;
  localparam int unsigned P_23 = 10, P_32 = 11, P_31 = 12;
  localparam int unsigned P_13 = 13, P_12 = 14, P_21 = 15;
  localparam int unsigned NP = 16;

  logic     p_vld_q;
  op_e      p_op_q;
  quat_t    p_a_q, p_b_q;
  prod_t    pr_q [NP];
  prod_t    pr_d [NP];
  quat_t    bb;
  logic     sq_op, p_slow, p_adv, fast_fire;
  wide_t    sq_sum;
  result_t  fres, seq_res;
  seq_cmd_t seq_cmd;
  seq_sts_t seq_sts;
  logic     out_vld_q;
  result_t  out_q;

  function automatic prod_t mul(input fx_t x, input fx_t y);
    prod_t p;
    p = x * y;
    return p;
  endfunction

  function automatic wide_t ext(input prod_t t);
    return SW'(t);
  endfunction

  function automatic wide_t extc(input fx_t c);
    return SW'(c);
  endfunction

  function automatic sat_t sat_sh(input wide_t v);
    return sat32(v >>> FRAC_BITS);
  endfunction

  assign sq_op = head_i.op inside {OP_NORMSQ, OP_NORM, OP_UNIT, OP_INV};
  assign bb    = sq_op ? head_i.a : head_i.b;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pr_d[i] = mul($signed(head_i.a[i]), $signed(bb[i]));
    end
    pr_d[P_S1] = mul($signed(head_i.a[1]), $signed(bb[0]));
    pr_d[P_S2] = mul($signed(head_i.a[2]), $signed(bb[0]));
    pr_d[P_S3] = mul($signed(head_i.a[3]), $signed(bb[0]));
    pr_d[P_01] = mul($signed(head_i.a[0]), $signed(bb[1]));
    pr_d[P_02] = mul($signed(head_i.a[0]), $signed(bb[2]));
    pr_d[P_03] = mul($signed(head_i.a[0]), $signed(bb[3]));
    pr_d[P_23] = mul($signed(head_i.a[2]), $signed(bb[3]));
    pr_d[P_32] = mul($signed(head_i.a[3]), $signed(bb[2]));
    pr_d[P_31] = mul($signed(head_i.a[3]), $signed(bb[1]));
    pr_d[P_13] = mul($signed(head_i.a[1]), $signed(bb[3]));
    pr_d[P_12] = mul($signed(head_i.a[1]), $signed(bb[2]));
    pr_d[P_21] = mul($signed(head_i.a[2]), $signed(bb[1]));
  end

  assign p_slow    = p_op_q inside {OP_NORM, OP_UNIT, OP_INV};
  assign p_adv     = p_vld_q && seq_sts.idle;
  assign fast_fire = p_adv && !p_slow;
  assign pop_o     = head_vld_i && (!p_vld_q || p_adv);

  assign sq_sum = ext(pr_q[P_D0]) + ext(pr_q[P_D1]) + ext(pr_q[P_D2]) + ext(pr_q[P_D3]);

  always_comb begin
    sat_t t0, t1, t2, t3;
    fres = '0;
    t0 = '0;
    t1 = '0;
    t2 = '0;
    t3 = '0;
    case (p_op_q)
      OP_ADD: begin
        t0 = sat32(extc(p_a_q[0]) + extc(p_b_q[0]));
        t1 = sat32(extc(p_a_q[1]) + extc(p_b_q[1]));
        t2 = sat32(extc(p_a_q[2]) + extc(p_b_q[2]));
        t3 = sat32(extc(p_a_q[3]) + extc(p_b_q[3]));
      end
      OP_ADDVEC: begin
        t0.v = p_a_q[0];
        t1 = sat32(extc(p_a_q[1]) + extc(p_b_q[1]));
        t2 = sat32(extc(p_a_q[2]) + extc(p_b_q[2]));
        t3 = sat32(extc(p_a_q[3]) + extc(p_b_q[3]));
      end
      OP_SCALE: begin
        t0 = sat_sh(ext(pr_q[P_D0]));
        t1 = sat_sh(ext(pr_q[P_S1]));
        t2 = sat_sh(ext(pr_q[P_S2]));
        t3 = sat_sh(ext(pr_q[P_S3]));
      end
      OP_CONJ: begin
        t0.v = p_a_q[0];
        t1 = sat32(-extc(p_a_q[1]));
        t2 = sat32(-extc(p_a_q[2]));
        t3 = sat32(-extc(p_a_q[3]));
      end
      OP_NEG: begin
        t0 = sat32(-extc(p_a_q[0]));
        t1 = sat32(-extc(p_a_q[1]));
        t2 = sat32(-extc(p_a_q[2]));
        t3 = sat32(-extc(p_a_q[3]));
      end
      OP_PRODUCT: begin
        t0 = sat_sh(ext(pr_q[P_D0]) - ext(pr_q[P_D1]) - ext(pr_q[P_D2])
                    - ext(pr_q[P_D3]));
        t1 = sat_sh(ext(pr_q[P_01]) + ext(pr_q[P_S1]) + ext(pr_q[P_23])
                    - ext(pr_q[P_32]));
        t2 = sat_sh(ext(pr_q[P_02]) + ext(pr_q[P_S2]) + ext(pr_q[P_31])
                    - ext(pr_q[P_13]));
        t3 = sat_sh(ext(pr_q[P_03]) + ext(pr_q[P_S3]) + ext(pr_q[P_12])
                    - ext(pr_q[P_21]));
      end
      OP_DOT, OP_NORMSQ: begin
        t0 = sat_sh(sq_sum);
        fres.s = t0.v;
        fres.ov = t0.ov;
        t0 = '0;
      end
      OP_EQUAL: begin
        fres.eq = (p_a_q == p_b_q);
      end
      default: begin
      end
    endcase
    fres.r[0] = t0.v;
    fres.r[1] = t1.v;
    fres.r[2] = t2.v;
    fres.r[3] = t3.v;
    fres.ov   = fres.ov | t0.ov | t1.ov | t2.ov | t3.ov;
  end

  assign seq_cmd.go = p_adv && p_slow;
  assign seq_cmd.op = p_op_q;

  qalu_seq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (seq_cmd),
    .sum_i (sq_sum[QW-1:0]),
    .a_i   (p_a_q),
    .sts_o (seq_sts),
    .res_o (seq_res)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_op_q <= head_i.op;
      p_a_q  <= head_i.a;
      p_b_q  <= head_i.b;
      for (int k = 0; k < NP; k++) begin
        pr_q[k] <= pr_d[k];
      end
    end
    if (seq_sts.fin) begin
      out_q <= seq_res;
    end else if (fast_fire) begin
      out_q <= fres;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        p_vld_q <= 1'b1;
      end else if (p_adv) begin
        p_vld_q <= 1'b0;
      end
      out_vld_q <= seq_sts.fin || fast_fire;
    end
  end

  assign out_vld_o = out_vld_q;
  assign res_o     = out_q;

endmodule

`default_nettype wire

// ===== bench/quaternion_alu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_alu_checker
// Watches the command and result channels of the quaternion ALU, works out
// the expected result of every accepted item and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_alu_checker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic            busy,
  input  wire logic [3:0]      opcode_i,
  input  wire qalu_pkg::quat_t a_i,
  input  wire qalu_pkg::quat_t b_i,
  input  wire logic            done_o,
  input  wire qalu_pkg::quat_t r_i,
  input  wire qalu_pkg::fx_t   scalar_i,
  input  wire logic            eq_i,
  input  wire logic            ov_i,
  input  wire logic            dz_i,
  output int                   errors_o,
  output int                   pending_o
);
  import qalu_pkg::*;

  localparam int FB = 16;

  result_t awaited_q[$];

  assign pending_o = awaited_q.size();

  initial errors_o = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors_o++;
  endtask

  // Clamp to 32 bits, raising the overflow flag when the value does not fit.
  function automatic fx_t clamp(input logic signed [65:0] v, inout logic ov);
    if (v > 66'sh0_7fff_ffff) begin
      ov = 1'b1;
      return FX_MAX;
    end
    if (v < -66'sh0_8000_0000) begin
      ov = 1'b1;
      return FX_MIN;
    end
    return v[31:0];
  endfunction

  // Floor of the exact square root.
  function automatic logic [33:0] floor_root(input logic [65:0] v);
    logic [65:0] rem, res, bitv;
    rem = v;
    res = '0;
    bitv = 66'd1 << 64;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[33:0];
  endfunction

  function automatic result_t quat_result(input logic [3:0] op, input quat_t a,
                                          input quat_t b);
    result_t res;
    fx_t aw, ax, ay, az, bw, bx, by, bz, ai;
    logic signed [65:0] acc;
    logic signed [33:0] wide_ai;
    logic [65:0] sumsq;
    logic [127:0] num, den, quo, lim;
    logic neg;
    int i;
    res = '0;
    aw = a[0]; ax = a[1]; ay = a[2]; az = a[3];
    bw = b[0]; bx = b[1]; by = b[2]; bz = b[3];
    acc = aw * aw + ax * ax + ay * ay + az * az;
    sumsq = acc;
    case (op)
      OP_ADD: begin
        for (i = 0; i < 4; i++)
          res.r[i] = clamp(66'($signed(a[i])) + 66'($signed(b[i])), res.ov);
      end
      OP_ADDVEC: begin
        res.r[0] = aw;
        for (i = 1; i < 4; i++)
          res.r[i] = clamp(66'($signed(a[i])) + 66'($signed(b[i])), res.ov);
      end
      OP_DOT: begin
        acc = aw * bw + ax * bx + ay * by + az * bz;
        res.s = clamp(acc >>> FB, res.ov);
      end
      OP_SCALE: begin
        for (i = 0; i < 4; i++) begin
          ai = a[i];
          acc = ai * bw;
          res.r[i] = clamp(acc >>> FB, res.ov);
        end
      end
      OP_CONJ: begin
        res.r[0] = aw;
        for (i = 1; i < 4; i++) res.r[i] = clamp(-66'($signed(a[i])), res.ov);
      end
      OP_NEG: begin
        for (i = 0; i < 4; i++) res.r[i] = clamp(-66'($signed(a[i])), res.ov);
      end
      OP_NORMSQ: begin
        res.s = clamp($signed(sumsq >> FB), res.ov);
      end
      OP_NORM: begin
        res.s = clamp($signed({32'd0, floor_root(sumsq)}), res.ov);
      end
      OP_UNIT, OP_INV: begin
        if (sumsq == 0) begin
          res.dz = 1'b1;
        end else begin
          for (i = 0; i < 4; i++) begin
            ai = a[i];
            wide_ai = ai;
            neg = ai < 0;
            num = (neg ? -wide_ai : wide_ai);
            if (op == OP_UNIT) begin
              num = num << FB;
              den = floor_root(sumsq);
            end else begin
              num = num << (2 * FB);
              den = sumsq;
              if (i > 0) neg = !neg;
            end
            if (ai == 0) neg = 1'b0;
            quo = num / den;
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (quo > lim) begin
              res.ov = 1'b1;
              quo = lim;
            end
            res.r[i] = neg ? -quo[31:0] : quo[31:0];
          end
        end
      end
      OP_PRODUCT: begin
        acc = aw * bw - ax * bx - ay * by - az * bz;
        res.r[0] = clamp(acc >>> FB, res.ov);
        acc = aw * bx + bw * ax + ay * bz - az * by;
        res.r[1] = clamp(acc >>> FB, res.ov);
        acc = aw * by + bw * ay + az * bx - ax * bz;
        res.r[2] = clamp(acc >>> FB, res.ov);
        acc = aw * bz + bw * az + ax * by - ay * bx;
        res.r[3] = clamp(acc >>> FB, res.ov);
      end
      OP_EQUAL: begin
        res.eq = (a == b);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni) begin
      if (start && !busy) awaited_q.push_back(quat_result(opcode_i, a_i, b_i));
      if (done_o) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          exp_r = awaited_q.pop_front();
          for (int i = 0; i < 4; i++)
            if (r_i[i] !== exp_r.r[i])
              report_mismatch($sformatf("r[%0d] got %h want %h", i, r_i[i], exp_r.r[i]));
          if (scalar_i !== exp_r.s)
            report_mismatch($sformatf("scalar got %h want %h", scalar_i, exp_r.s));
          if (eq_i !== exp_r.eq)
            report_mismatch($sformatf("equal flag got %b want %b", eq_i, exp_r.eq));
          if (ov_i !== exp_r.ov)
            report_mismatch($sformatf("overflow flag got %b want %b", ov_i, exp_r.ov));
          if (dz_i !== exp_r.dz)
            report_mismatch($sformatf("divzero flag got %b want %b", dz_i, exp_r.dz));
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/quaternion_alu_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_alu_tb
// Drives directed and random items into the quaternion ALU under several
// sender idling regimes; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_alu_tb;
  import qalu_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1200;
  localparam fx_t ONE           = 32'sh0001_0000;
  localparam fx_t ZERO          = 32'sh0000_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [3:0]  opcode_i;
  quat_t       a_q, b_q;
  logic        done_o;
  logic [31:0] r_w_o, r_x_o, r_y_o, r_z_o, scalar_out_o;
  logic        equal_flag_o, overflow_flag_o, divzero_flag_o;
  int          errors, pending, quiet_cycles, idle_pct;
  bit          timed_out;

  quaternion_alu i_dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i,
    .a_w_i(a_q[0]), .a_x_i(a_q[1]), .a_y_i(a_q[2]), .a_z_i(a_q[3]),
    .b_w_i(b_q[0]), .b_x_i(b_q[1]), .b_y_i(b_q[2]), .b_z_i(b_q[3]),
    .done_o, .r_w_o, .r_x_o, .r_y_o, .r_z_o, .scalar_out_o,
    .equal_flag_o, .overflow_flag_o, .divzero_flag_o
  );

  quaternion_alu_checker i_checker (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .a_i(a_q), .b_i(b_q), .done_o,
    .r_i({r_z_o, r_y_o, r_x_o, r_w_o}), .scalar_i(scalar_out_o),
    .eq_i(equal_flag_o), .ov_i(overflow_flag_o), .dz_i(divzero_flag_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The watchdog ends the run when nothing at all has moved for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it, then perhaps
  // drop start for a random gap, according to the current idling phase.
  task automatic issue(input logic [3:0] op, input quat_t a, input quat_t b);
    start    <= 1'b1;
    opcode_i <= op;
    a_q      <= a;
    b_q      <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Operand values lean towards the interesting corners now and then.
  function automatic fx_t pick_value();
    case ($urandom_range(9))
      0: return FX_MAX;
      1: return FX_MIN;
      2: return '0;
      3: return fx_t'($signed($urandom_range(0, 2 * ONE))) - ONE;
      4: return fx_t'($signed($urandom_range(0, 255))) - 128;
      default: return fx_t'($urandom());
    endcase
  endfunction

  function automatic quat_t pick_quat();
    quat_t q;
    for (int i = 0; i < 4; i++) q[i] = pick_value();
    return q;
  endfunction

  initial begin
    quat_t a, b;
    logic [3:0] op;
    int phase_pct[4];
    // No idling, sender idle, receiver stalling (it cannot), both idle.
    phase_pct = '{0, 88, 0, 23};
    quiet_cycles = 0;
    idle_pct = 0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    opcode_i = OP_ADD;
    a_q      = '0;
    b_q      = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: saturation each way, negating the most negative
    // value, a squared norm that carries past 64 bits, zero in normalise and
    // inverse, an inverse too large to fit, basis products and equality.
    issue(OP_ADD, {4{FX_MAX}}, {4{FX_MAX}});
    issue(OP_ADD, {4{FX_MIN}}, {4{FX_MIN}});
    issue(OP_ADDVEC, {FX_MAX, FX_MAX, FX_MIN, ONE}, {FX_MAX, ONE, -ONE, ONE});
    issue(OP_DOT, {4{FX_MIN}}, {4{FX_MIN}});
    issue(OP_DOT, {ONE, -ONE, ONE, 32'sd3}, {32'sd5, ONE, -ONE, -32'sd7});
    issue(OP_SCALE, {FX_MIN, FX_MAX, ONE, -32'sd1}, {-ONE, ZERO, ZERO, ZERO});
    issue(OP_CONJ, {FX_MIN, FX_MIN, FX_MAX, ZERO}, '0);
    issue(OP_NEG, {FX_MIN, FX_MAX, -32'sd1, ZERO}, '0);
    issue(OP_NORMSQ, {4{FX_MIN}}, '0);
    issue(OP_NORMSQ, {ONE, ONE, ZERO, ZERO}, '0);
    issue(OP_NORM, {4{FX_MIN}}, '0);
    issue(OP_NORM, {ONE, ZERO, ZERO, ZERO}, '0);
    issue(OP_UNIT, '0, '0);
    issue(OP_INV, '0, '0);
    issue(OP_UNIT, {-ONE, ONE, ZERO, 32'sd1}, '0);
    issue(OP_INV, {2 * ONE, ZERO, -ONE, ZERO}, '0);
    issue(OP_INV, {ZERO, ZERO, 32'sd1, ZERO}, '0);
    issue(OP_UNIT, {4{FX_MIN}}, '0);
    issue(OP_INV, {4{FX_MIN}}, '0);
    issue(OP_PRODUCT, {ZERO, ZERO, ONE, ZERO}, {ZERO, ONE, ZERO, ZERO});
    issue(OP_PRODUCT, {4{FX_MIN}}, {4{FX_MAX}});
    issue(OP_EQUAL, {FX_MIN, ONE, ZERO, FX_MAX}, {FX_MIN, ONE, ZERO, FX_MAX});
    issue(OP_EQUAL, {FX_MIN, ONE, ZERO, FX_MAX}, {FX_MIN, ONE, 32'sd1, FX_MAX});
    issue(OP_NONE, {4{FX_MAX}}, {4{FX_MIN}});

    // Random items in four idling phases. The slow root and divider
    // operations are drawn more often than the others.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = phase_pct[n * 4 / RANDOM_ITEMS];
      if ($urandom_range(9) < 2) op = op_e'($urandom_range(OP_NORM, OP_INV));
      else op = 4'($urandom_range(15));
      a = pick_quat();
      b = ($urandom_range(3) == 0) ? a : pick_quat();
      if (op == OP_EQUAL && $urandom_range(1)) b[$urandom_range(3)] ^= 32'($urandom_range(1));
      issue(op, a, b);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
